// File: rtl/half_single_float_converter_macros.svh
// Assertion macros for the half/single converter checker
`ifndef HALF_SINGLE_FLOAT_CONVERTER_MACROS_SVH
`define HALF_SINGLE_FLOAT_CONVERTER_MACROS_SVH

// implication checked on every clock, off during reset
`define HSFC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked on every clock, off during reset
`define HSFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hsfc_pkg.sv
// Shared constants and types for the half/single converter
package hsfc_pkg;
    localparam int WORD_W = 32;

    localparam logic CMD_H2S = 1'b0;
    localparam logic CMD_S2H = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
endpackage

// File: rtl/hsfc_convert.sv
// Combinational half<->single bit-pattern conversion
module hsfc_convert (
    input  logic          i_cmd,
    input  hsfc_pkg::t_word i_src,
    output hsfc_pkg::t_word o_res
);
    import hsfc_pkg::*;

    logic        h_s;
    logic [4:0]  h_e;
    logic [9:0]  h_m;
    logic [3:0]  h_p;
    logic [7:0]  h2s_e;
    logic [22:0] h2s_m;
    logic [9:0]  h_mn;

    logic        f_s;
    logic [7:0]  f_e;
    logic [22:0] f_m;
    logic [4:0]  s2h_e;
    logic [9:0]  s2h_m;
    logic [23:0] f_full;
    logic [4:0]  f_sh;

    // leading-one position of a half denormal mantissa
    always_comb begin
        h_p = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (h_m[i]) begin
                h_p = 4'(i);
            end
        end
    end

    assign h_s = i_src[15];
    assign h_e = i_src[14:10];
    assign h_m = i_src[9:0];
    assign h_mn = h_m << (4'd10 - h_p);

    always_comb begin
        if (h_e == 5'd0) begin
            if (h_m == 10'd0) begin
                h2s_e = 8'd0;
                h2s_m = 23'd0;
            end else begin
                h2s_e = 8'(h_p) + 8'd103;
                h2s_m = {h_mn, 13'd0};
            end
        end else if (h_e == 5'd31) begin
            h2s_e = 8'hff;
            h2s_m = {22'd0, h_m != 10'd0};
        end else begin
            h2s_e = 8'(h_e) + 8'd112;
            h2s_m = {h_m, 13'd0};
        end
    end

    assign f_s = i_src[31];
    assign f_e = i_src[30:23];
    assign f_m = i_src[22:0];
    assign f_full = {1'b1, f_m};
    // shift 14..23 for exponent fields 103..112
    assign f_sh = 5'd14 + 5'(8'd112 - f_e);

    always_comb begin
        if (f_e == 8'd0 || f_e < 8'd103) begin
            s2h_e = 5'd0;
            s2h_m = 10'd0;
        end else if (f_e == 8'hff) begin
            s2h_e = 5'd31;
            s2h_m = {9'd0, f_m != 23'd0};
        end else if (f_e < 8'd113) begin
            s2h_e = 5'd0;
            s2h_m = 10'(f_full >> f_sh);
        end else if (f_e > 8'd142) begin
            s2h_e = 5'd31;
            s2h_m = 10'd0;
        end else begin
            s2h_e = 5'(f_e - 8'd112);
            s2h_m = f_m[22:13];
        end
    end

    assign o_res = (i_cmd == CMD_H2S) ? {h_s, h2s_e, h2s_m}
                                      : {16'd0, f_s, s2h_e, s2h_m};
endmodule

// File: rtl/half_single_float_converter.sv
// Top level: registered half/single float converter
//  channel | signals                               | dir
//  in      | i_valid, o_stall, i_command, i_operand_bits | sink
//  out     | o_valid, i_stall, o_result_bits        | source
// One word per cycle while i_stall does not hold a result; o_valid rises in the cycle after input acceptance.
// The single result register behind the conversion logic holds the result.
// Synchronous active-low reset clears o_valid only.
// o_stall follows i_stall only while a result is held.
module half_single_float_converter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_command,
    input  hsfc_pkg::t_word i_operand_bits,
    output logic            o_valid,
    input  logic            i_stall,
    output hsfc_pkg::t_word o_result_bits
);
    import hsfc_pkg::*;

    t_word r_res;
    t_word n_res;
    logic  r_valid;
    logic  w_load;

    hsfc_convert u_conv (
        .i_cmd (i_command),
        .i_src (i_operand_bits),
        .o_res (n_res)
    );

    assign o_stall = r_valid && i_stall;
    assign w_load  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (w_load) begin
            r_res <= n_res;
        end
    end

    assign o_valid       = r_valid;
    assign o_result_bits = r_res;
endmodule

// File: rtl/hsfc_checker.sv
// Port-level checker for the half/single converter, bound to the top level
`include "half_single_float_converter_macros.svh"
module hsfc_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input logic            i_command,
    input hsfc_pkg::t_word o_result_bits
);
    `HSFC_ASSERT_NEXT(a_accept_gives_valid, i_clk, i_rst_n, i_valid && !o_stall, o_valid, "accepted word lost")
    `HSFC_ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, o_stall, o_valid, "stall without held result")
    `HSFC_ASSERT_NEXT(a_held_stable, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_result_bits), "held result changed")
    `HSFC_ASSERT_NEXT(a_half_upper_zero, i_clk, i_rst_n, i_valid && !o_stall && i_command == hsfc_pkg::CMD_S2H, o_result_bits[31:16] == 16'd0, "half result upper bits set")
endmodule

bind half_single_float_converter hsfc_checker u_hsfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .i_command     (i_command),
    .o_result_bits (o_result_bits)
);
